FILE: rtl/fdf_pkg.sv
// Shared types and constants for the fractional-delay FIR frame filter.
// No dependencies.
package fdf_pkg;

	typedef logic signed [15:0] word_t;
	typedef logic signed [31:0] prod_t;

	localparam logic MODE_COEF   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam int WORD_W     = 16;
	localparam int FRAC_DROP  = 14;
	localparam int ROUND_HALF = 8192;

endpackage

FILE: rtl/fractional_delay_fir_frame.sv
// Fractional-delay FIR frame filter: tap table and history line in
// synchronous-read memories, one shared multiply-accumulate unit.
// Depends on fdf_pkg.
//
// Use:
//   Input channel (in_valid, in_stall, mode, tap_index, value, last) carries
//   one word per accepted handshake. mode 0 loads a Q2.14 coefficient into
//   slot tap_index (slots at or past TAPS are ignored) and gives no output.
//   mode 1 pushes a Q15 sample; last closes the frame.
//   Output channel (out_valid, out_stall, sample_out, frame_end) gives one
//   rounded, saturated Q15 word per output; frame_end marks the frame's final.
//   A coefficient word, or a sample word that yields no output, leaves the
//   block idle. Each output runs a pass of tap reads through the shared
//   multiplier, a drain while the read, product and accumulate registers
//   empty, and an emit step, with the next input taken the cycle after the
//   final emit. A closing sample gives up to TAPS - LOOK_BACK outputs back
//   to back.
//   in_stall stays high from the acceptance of a sample that yields output
//   until its last output has entered the output register. A stalled
//   receiver holds that register and the block waits in its emit step.
//   Reset clears the tap table valid flags, the frame count and the output
//   valid flag; the history needs no clearing pass, since entries older than
//   the frame's sample count read as zero.
module fractional_delay_fir_frame
	import fdf_pkg::*;
#(
	parameter int TAPS      = 16,
	parameter int LOOK_BACK = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [3:0]  tap_index,
	input  word_t       value,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output word_t       sample_out,
	output logic        frame_end
);

	localparam int AHEAD = TAPS - 1 - LOOK_BACK;
	localparam int KW    = $clog2(TAPS);
	localparam int CW    = $clog2(TAPS + 1);
	localparam int DW    = (AHEAD > 0) ? $clog2(AHEAD + 1) : 1;
	localparam int IW    = KW + DW + 2;
	localparam int AW    = 32 + KW;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MAC   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	word_t             coef_mem [TAPS];
	word_t             hist_mem [TAPS];
	logic [TAPS-1:0]   coef_vld_q;

	logic [1:0]        state_q;
	logic [KW-1:0]     ptr_q;
	logic [CW-1:0]     cnt_q;
	logic [KW-1:0]     k_q;
	logic [DW-1:0]     d_q;
	logic              last_q;

	word_t             coef_s1, hist_s1;
	logic              use_s1, v_s1, first_s1, lastk_s1;
	prod_t             prod_s2;
	logic              v_s2, first_s2, lastk_s2;
	logic signed [AW-1:0] acc_q;
	logic              acc_rdy_q;

	logic              out_valid_q, frame_end_q;
	word_t             sample_out_q;

	logic              in_acc, coef_wr, smp_wr, emit_go, emit_done;
	logic [KW-1:0]     ptr_nxt;
	logic [CW-1:0]     cnt_nxt;
	logic [CW-1:0]     fill_j;
	logic [DW-1:0]     d_start;
	logic              will_emit;
	logic signed [IW-1:0] idx;
	logic              idx_ok;
	logic [KW-1:0]     idx_k;
	logic [KW:0]       addr_w;
	logic [KW-1:0]     hist_addr;
	logic signed [AW-1:0] rnd, qv;
	word_t             sat_v;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign coef_wr  = in_acc && (mode == MODE_COEF) && (32'(tap_index) < 32'(TAPS));
	assign smp_wr   = in_acc && (mode == MODE_SAMPLE);

	assign ptr_nxt  = (ptr_q == KW'(TAPS - 1)) ? '0 : ptr_q + 1'b1;
	assign cnt_nxt  = (cnt_q == CW'(TAPS)) ? cnt_q : cnt_q + 1'b1;
	assign fill_j   = (32'(cnt_q) >= AHEAD) ? CW'(AHEAD) : cnt_q;
	assign d_start  = (last && (32'(fill_j) < AHEAD)) ? DW'(AHEAD - 32'(fill_j)) : '0;
	assign will_emit = last || (32'(fill_j) >= AHEAD);

	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign emit_done = last_q ? (d_q == DW'(AHEAD)) : 1'b1;

	always_comb begin
		idx       = IW'(TAPS - 1) - IW'(k_q) - IW'(d_q);
		idx_ok    = (idx >= 0) && (idx < $signed(IW'(cnt_q)));
		idx_k     = idx[KW-1:0];
		addr_w    = (KW+1)'(ptr_q) + ((ptr_q < idx_k) ? (KW+1)'(TAPS) : '0)
		            - (KW+1)'(idx_k);
		hist_addr = addr_w[KW-1:0];
	end

	always_comb begin
		rnd = acc_q + AW'(ROUND_HALF);
		qv  = rnd >>> FRAC_DROP;
		if (qv[AW-1] && !(&qv[AW-1:WORD_W-1])) begin
			sat_v = {1'b1, {(WORD_W-1){1'b0}}};
		end else if (!qv[AW-1] && (|qv[AW-1:WORD_W-1])) begin
			sat_v = {1'b0, {(WORD_W-1){1'b1}}};
		end else begin
			sat_v = qv[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (coef_wr) begin
			coef_mem[KW'(tap_index)] <= value;
		end
		if (smp_wr) begin
			hist_mem[ptr_nxt] <= value;
		end
		coef_s1 <= coef_mem[k_q];
		hist_s1 <= hist_mem[hist_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (coef_wr) begin
			coef_vld_q[KW'(tap_index)] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			d_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (smp_wr) begin
						ptr_q  <= ptr_nxt;
						cnt_q  <= cnt_nxt;
						k_q    <= '0;
						d_q    <= d_start;
						last_q <= last;
						if (will_emit) begin
							state_q <= S_MAC;
						end
					end
				end
				S_MAC: begin
					if (k_q == KW'(TAPS - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (acc_rdy_q) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						k_q <= '0;
						if (emit_done) begin
							state_q <= S_IDLE;
							if (last_q) begin
								cnt_q <= '0;
							end
						end else begin
							d_q     <= d_q + 1'b1;
							state_q <= S_MAC;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			acc_rdy_q <= 1'b0;
		end else begin
			v_s1      <= (state_q == S_MAC);
			v_s2      <= v_s1;
			acc_rdy_q <= v_s2 && lastk_s2;
		end
	end

	always_ff @(posedge clk) begin
		use_s1   <= idx_ok && coef_vld_q[k_q];
		first_s1 <= (k_q == '0);
		lastk_s1 <= (k_q == KW'(TAPS - 1));
		prod_s2  <= use_s1 ? prod_t'(coef_s1 * hist_s1) : '0;
		first_s2 <= first_s1;
		lastk_s2 <= lastk_s1;
		if (v_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + AW'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			sample_out_q <= sat_v;
			frame_end_q  <= last_q && (d_q == DW'(AHEAD));
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign frame_end  = frame_end_q;

	a_busy_has_samples: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (cnt_q != '0))
		else $error("filter busy with an empty frame");

	a_acc_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		acc_rdy_q |-> (state_q == S_DRAIN))
		else $error("accumulator completed outside drain");

	a_coef_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (mode == MODE_COEF)) |=> (state_q == S_IDLE))
		else $error("coefficient word started a computation");

	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && last_q && (d_q == DW'(AHEAD))) |=> (cnt_q == '0) && (state_q == S_IDLE))
		else $error("frame not closed after final output");

endmodule

FILE: tb/sv/fractional_delay_fir_frame_tb.sv
// Self-checking testbench for fractional_delay_fir_frame: drives coefficient and
// sample words, predicts every filtered output and compares it with the block.
// Depends on fdf_pkg and the fractional_delay_fir_frame RTL.
module fractional_delay_fir_frame_tb;
	import fdf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAPS      = 16;
	localparam int LOOK_BACK = 8;
	localparam int AHEAD     = TAPS - 1 - LOOK_BACK;
	localparam int SETTLE    = 4 * (TAPS + 4);

	typedef struct packed {
		word_t sample;
		logic  frame_end;
	} fir_out_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic       mode      = MODE_COEF;
	logic [3:0] tap_index = '0;
	word_t      value     = '0;
	logic       last      = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	word_t      sample_out;
	logic       frame_end;

	word_t    coef_tbl [TAPS];
	word_t    hist_line [TAPS];
	int       fill_cnt;
	fir_out_t filtered_q [$];
	fir_out_t head_out;
	int       err_count     = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;

	fractional_delay_fir_frame #(
		.TAPS(TAPS),
		.LOOK_BACK(LOOK_BACK)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.tap_index(tap_index),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.frame_end(frame_end)
	);

	always #2 clk = ~clk;

	initial begin
		#4ms;
		$display("fractional_delay_fir_frame_tb: done, errors");
		$finish;
	end

	function automatic word_t tap_sum(input int d);
		longint acc;
		longint q;
		int     idx;
		acc = 0;
		for (int k = 0; k < TAPS; k++) begin
			idx = TAPS - 1 - k - d;
			if (idx >= 0)
				acc += longint'(coef_tbl[k]) * longint'(hist_line[idx]);
		end
		q = (acc + ROUND_HALF) >>> FRAC_DROP;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return word_t'(q);
	endfunction

	function automatic void predict_word(input logic m, input logic [3:0] ti, input word_t v,
			input logic l);
		int       j;
		int       dstart;
		fir_out_t e;
		if (m == MODE_COEF) begin
			if (int'(ti) < TAPS)
				coef_tbl[ti] = v;
			return;
		end
		for (int k = TAPS - 1; k > 0; k--)
			hist_line[k] = hist_line[k - 1];
		hist_line[0] = v;
		j = fill_cnt;
		if (fill_cnt < AHEAD)
			fill_cnt++;
		if (!l) begin
			if (j >= AHEAD) begin
				e.sample    = tap_sum(0);
				e.frame_end = 1'b0;
				filtered_q.push_back(e);
			end
			return;
		end
		dstart = (j >= AHEAD) ? 0 : AHEAD - j;
		for (int d = dstart; d <= AHEAD; d++) begin
			e.sample    = tap_sum(d);
			e.frame_end = (d == AHEAD);
			filtered_q.push_back(e);
		end
		for (int k = 0; k < TAPS; k++)
			hist_line[k] = '0;
		fill_cnt = 0;
	endfunction

	task automatic send_word(input logic m, input logic [3:0] ti, input word_t v, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		tap_index <= ti;
		value     <= v;
		last      <= l;
		do @(posedge clk); while (in_stall);
		predict_word(m, ti, v, l);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (filtered_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (filtered_q.size() == 0) begin
				$display("%0t unexpected word: expected none, actual %0d frame_end %0b",
					$time, sample_out, frame_end);
				err_count++;
			end else begin
				head_out = filtered_q.pop_front();
				if (sample_out !== head_out.sample) begin
					$display("%0t sample_out mismatch: expected %0d, actual %0d",
						$time, head_out.sample, sample_out);
					err_count++;
				end
				if (frame_end !== head_out.frame_end) begin
					$display("%0t frame_end mismatch: expected %0b, actual %0b",
						$time, head_out.frame_end, frame_end);
					err_count++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic test_coef_extremes();
		send_word(MODE_COEF, 4'd0, 16'sh7fff, 1'b0);
		send_word(MODE_COEF, 4'd15, 16'sh8000, 1'b1);
		send_word(MODE_COEF, 4'd8, 16'sh4000, 1'b0);
	endtask

	task automatic test_short_frames();
		send_word(MODE_SAMPLE, 4'd15, 16'sh7fff, 1'b1);
		send_word(MODE_SAMPLE, 4'd0, 16'sh8000, 1'b0);
		send_word(MODE_SAMPLE, 4'd5, 16'sh1234, 1'b0);
		send_word(MODE_SAMPLE, 4'd10, 16'sh7fff, 1'b1);
	endtask

	task automatic test_full_frame();
		for (int i = 0; i < 10; i++)
			send_word(MODE_SAMPLE, 4'(i), (i % 2) ? 16'sh8000 : 16'sh7fff, i == 9);
	endtask

	task automatic test_saturation();
		for (int k = 1; k <= 4; k++)
			send_word(MODE_COEF, 4'(k), 16'sh7fff, 1'b0);
		send_word(MODE_SAMPLE, 4'd0, 16'sh7fff, 1'b0);
		send_word(MODE_SAMPLE, 4'd0, 16'sh7fff, 1'b0);
		send_word(MODE_SAMPLE, 4'd0, 16'sh8000, 1'b1);
	endtask

	task automatic test_random_frames(input int n_items, input int s_idle, input int r_idle);
		int    sent;
		int    flen;
		word_t coef;
		sent          = 0;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		while (sent < n_items) begin
			flen = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
			for (int i = 0; i < flen; i++) begin
				if ($urandom_range(99) < 12) begin
					coef = ($urandom_range(3) == 0) ? word_t'($urandom)
						: word_t'($urandom_range(8191)) - 16'sd4096;
					send_word(MODE_COEF, 4'($urandom_range(15)), coef, 1'($urandom_range(1)));
					sent++;
				end
				send_word(MODE_SAMPLE, 4'($urandom_range(15)), word_t'($urandom), i == flen - 1);
				sent++;
			end
			if ($urandom_range(19) == 0)
				wait_drained();
		end
	endtask

	initial begin
		for (int k = 0; k < TAPS; k++) begin
			coef_tbl[k]  = '0;
			hist_line[k] = '0;
		end
		fill_cnt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 8;
		recv_idle_pct = 65;
		test_coef_extremes();
		test_short_frames();
		test_full_frame();
		test_saturation();
		test_random_frames(100, 8, 65);
		wait_drained();
		test_random_frames(100, 65, 8);
		test_random_frames(100, 0, 0);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0 && filtered_q.size() == 0)
			$display("fractional_delay_fir_frame_tb: done, clean");
		else
			$display("fractional_delay_fir_frame_tb: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/fdf_pkg.sv
rtl/fractional_delay_fir_frame.sv
tb/sv/fractional_delay_fir_frame_tb.sv
